>>> hdl/fcnc_pkg.sv
package fcnc_pkg;

  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned DIST_W      = 10;
  localparam int unsigned RATE_W      = 16;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned WORD_W      = 40;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 56;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_WORD0 = 3'd1;

  localparam logic [DIST_W-1:0] NO_MATCH_DIST = 10'd765;

  // wheel rate = (speed * 1000 + 571) / 1143, divide done as multiply by 2^32/1143
  localparam int unsigned RATE_X_W    = 26;
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [RATE_X_W-1:0] RATE_NUM  = 26'd1000;
  localparam logic [RATE_X_W-1:0] RATE_DEN  = 26'd1143;
  localparam logic [RATE_X_W-1:0] RATE_HALF = 26'd571;
  localparam logic [63:0] RATE_RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'd1143;
  localparam logic [RECIP_W-1:0] RATE_RECIP = RATE_RECIP_FULL[RECIP_W-1:0];

  localparam logic [IDX_W-1:0] DIV_LAST_STEP = 3'(COLOR_W - 1);

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DIV,
    ST_SEARCH,
    ST_RATE_MUL,
    ST_RATE_RECIP,
    ST_RATE_BACK,
    ST_RATE_FIX,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             acc;
    logic             load;
    logic             div;
    logic             search;
    logic [IDX_W-1:0] cls;
    logic             rate_mul;
    logic             rate_recip;
    logic             rate_back;
    logic             rate_fix;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] lim;
    logic             out_free;
  } sts_t;

endpackage

>>> hdl/frame_color_nearest_class.sv
// Mean-color nearest-class classifier. Pixels stream in one per cycle and are
// summed per channel; on the pixel with tlast the block stops taking items
// while it latches the sums, runs the shared bit-serial divider that forms the
// three truncated means, searches N = min(class_count, MAX_CLASSES) classes by
// L1 distance (one class per cycle), runs the speed-to-wheel-rate
// multiply-by-reciprocal path, and loads the result register (waiting while
// the previous result is still not taken). Pixels past MAX_FRAME_PIXELS in one
// frame are ignored; tlast still ends the frame.
// Config writes are meant to happen only while no frame is in progress.
module frame_color_nearest_class #(
  parameter int unsigned MAX_CLASSES      = 6,
  parameter int unsigned MAX_FRAME_PIXELS = 65536
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fcnc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fcnc_pkg::WORD_W-1:0]      cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fcnc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // red, green, blue
  input  logic                             s_axis_tlast,  // last_pixel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // class_index, best_distance, mean_red, mean_green, mean_blue, wheel_rate, pad
  output logic [fcnc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tuser   // matched
);

  fcnc_pkg::cmd_t cmd;
  fcnc_pkg::sts_t sts;

  fcnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcnc_dp #(
    .MAX_CLASSES      (MAX_CLASSES),
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pix_i         (s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_matched_o (m_axis_tuser)
  );

endmodule

>>> hdl/fcnc_ctrl.sv
module fcnc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  fcnc_pkg::sts_t sts_i,
  output fcnc_pkg::cmd_t cmd_o
);

  fcnc_pkg::state_e state_q, state_d;
  logic [fcnc_pkg::IDX_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcnc_pkg::ST_ACCUM;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.cls  = step_q;
    in_ready_o = 1'b0;
    case (state_q)
      fcnc_pkg::ST_ACCUM: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (in_last_i) state_d = fcnc_pkg::ST_LOAD;
        end
      end
      fcnc_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        step_d     = '0;
        state_d    = fcnc_pkg::ST_DIV;
      end
      fcnc_pkg::ST_DIV: begin
        cmd_o.div = 1'b1;
        if (step_q == fcnc_pkg::DIV_LAST_STEP) begin
          step_d  = '0;
          state_d = (sts_i.lim != '0) ? fcnc_pkg::ST_SEARCH : fcnc_pkg::ST_RATE_MUL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      fcnc_pkg::ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (step_q == sts_i.lim - 1'b1) begin
          step_d  = '0;
          state_d = fcnc_pkg::ST_RATE_MUL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      fcnc_pkg::ST_RATE_MUL: begin
        cmd_o.rate_mul = 1'b1;
        state_d        = fcnc_pkg::ST_RATE_RECIP;
      end
      fcnc_pkg::ST_RATE_RECIP: begin
        cmd_o.rate_recip = 1'b1;
        state_d          = fcnc_pkg::ST_RATE_BACK;
      end
      fcnc_pkg::ST_RATE_BACK: begin
        cmd_o.rate_back = 1'b1;
        state_d         = fcnc_pkg::ST_RATE_FIX;
      end
      fcnc_pkg::ST_RATE_FIX: begin
        cmd_o.rate_fix = 1'b1;
        state_d        = fcnc_pkg::ST_EMIT;
      end
      fcnc_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = fcnc_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_d = fcnc_pkg::ST_ACCUM;
        step_d  = '0;
      end
    endcase
  end

  // frame end must stop intake until the result is handed over
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_last_i |=> !in_ready_o)
    else $error("input accepted right after last pixel");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result register overwritten while occupied");

endmodule

>>> hdl/fcnc_dp.sv
module fcnc_dp #(
  parameter int unsigned MAX_CLASSES      = 6,
  parameter int unsigned MAX_FRAME_PIXELS = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fcnc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fcnc_pkg::WORD_W-1:0]         cfg_data_i,
  input  logic [fcnc_pkg::IN_TDATA_W-1:0]     pix_i,
  input  fcnc_pkg::cmd_t                      cmd_i,
  output fcnc_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fcnc_pkg::OUT_TDATA_W-1:0]    out_data_o,
  output logic                                out_matched_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int unsigned SUM_W = CNT_W + fcnc_pkg::COLOR_W;
  localparam int unsigned CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_PIXELS);
  localparam logic [fcnc_pkg::IDX_W-1:0] CLS_MAX = fcnc_pkg::IDX_W'(MAX_CLASSES);
  localparam int unsigned PROD_W = fcnc_pkg::RATE_X_W + fcnc_pkg::RECIP_W;

  // configuration
  logic [fcnc_pkg::IDX_W-1:0]  ccount_q;
  logic [fcnc_pkg::WORD_W-1:0] word_q [MAX_CLASSES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccount_q <= '0;
      for (int i = 0; i < MAX_CLASSES; i++) word_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fcnc_pkg::REG_CLASS_COUNT) ccount_q <= cfg_data_i[fcnc_pkg::IDX_W-1:0];
      for (int i = 0; i < MAX_CLASSES; i++) begin
        if (cfg_idx_i == fcnc_pkg::REG_CLASS_WORD0 + fcnc_pkg::CFG_IDX_W'(i)) begin
          word_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign sts_o.lim = (ccount_q > CLS_MAX) ? CLS_MAX : ccount_q;

  // accumulators
  logic [SUM_W-1:0] rsum_q, gsum_q, bsum_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsum_q <= '0;
      gsum_q <= '0;
      bsum_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.load) begin
      rsum_q <= '0;
      gsum_q <= '0;
      bsum_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.acc && (cnt_q < CNT_MAX)) begin
      rsum_q <= rsum_q + SUM_W'(pix_i[7:0]);
      gsum_q <= gsum_q + SUM_W'(pix_i[15:8]);
      bsum_q <= bsum_q + SUM_W'(pix_i[23:16]);
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  // restoring divide, one quotient bit per cycle for all three channels
  logic [SUM_W-1:0] rrem_q, grem_q, brem_q, dvs_q;
  logic [fcnc_pkg::COLOR_W-1:0] mr_q, mg_q, mb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rrem_q <= rsum_q;
      grem_q <= gsum_q;
      brem_q <= bsum_q;
      dvs_q  <= SUM_W'(cnt_q) << (fcnc_pkg::COLOR_W - 1);
    end else if (cmd_i.div) begin
      if (rrem_q >= dvs_q) rrem_q <= rrem_q - dvs_q;
      if (grem_q >= dvs_q) grem_q <= grem_q - dvs_q;
      if (brem_q >= dvs_q) brem_q <= brem_q - dvs_q;
      mr_q  <= {mr_q[fcnc_pkg::COLOR_W-2:0], rrem_q >= dvs_q};
      mg_q  <= {mg_q[fcnc_pkg::COLOR_W-2:0], grem_q >= dvs_q};
      mb_q  <= {mb_q[fcnc_pkg::COLOR_W-2:0], brem_q >= dvs_q};
      dvs_q <= dvs_q >> 1;
    end
  end

  // class search, one class per cycle
  logic [fcnc_pkg::WORD_W-1:0]  cw;
  logic [fcnc_pkg::COLOR_W:0]   dr, dg, db;
  logic [fcnc_pkg::DIST_W-1:0]  l1_dist;
  logic [fcnc_pkg::DIST_W-1:0]  best_q;
  logic [fcnc_pkg::IDX_W-1:0]   bidx_q;
  logic                         hit_q;
  logic [fcnc_pkg::SPEED_W-1:0] spd_q;

  always_comb begin
    cw      = word_q[cmd_i.cls[CLS_W-1:0]];
    dr      = (mr_q > cw[23:16]) ? {1'b0, mr_q - cw[23:16]} : {1'b0, cw[23:16] - mr_q};
    dg      = (mg_q > cw[15:8])  ? {1'b0, mg_q - cw[15:8]}  : {1'b0, cw[15:8] - mg_q};
    db      = (mb_q > cw[7:0])   ? {1'b0, mb_q - cw[7:0]}   : {1'b0, cw[7:0] - mb_q};
    l1_dist = fcnc_pkg::DIST_W'(dr) + fcnc_pkg::DIST_W'(dg) + fcnc_pkg::DIST_W'(db);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      best_q <= fcnc_pkg::NO_MATCH_DIST;
      bidx_q <= '0;
      hit_q  <= 1'b0;
      spd_q  <= '0;
    end else if (cmd_i.search && (l1_dist < best_q)) begin
      best_q <= l1_dist;
      bidx_q <= cmd_i.cls;
      hit_q  <= 1'b1;
      spd_q  <= cw[39:24];
    end
  end

  // speed to wheel rate: x = speed*1000 + 571, q = x*recip >> 32, fix by one
  logic [fcnc_pkg::RATE_X_W-1:0] rx_q, pr_q, rrem;
  logic [PROD_W-1:0]             prod;
  logic [fcnc_pkg::RATE_W-1:0]   qe_q, rate_q;

  assign prod = PROD_W'(rx_q) * PROD_W'(fcnc_pkg::RATE_RECIP);
  assign rrem = rx_q - pr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rate_mul) begin
      rx_q <= fcnc_pkg::RATE_X_W'(spd_q) * fcnc_pkg::RATE_NUM + fcnc_pkg::RATE_HALF;
    end
    if (cmd_i.rate_recip) begin
      qe_q <= prod[fcnc_pkg::RECIP_SHIFT +: fcnc_pkg::RATE_W];
    end
    if (cmd_i.rate_back) begin
      pr_q <= fcnc_pkg::RATE_X_W'(qe_q) * fcnc_pkg::RATE_DEN;
    end
    if (cmd_i.rate_fix) begin
      rate_q <= (rrem >= fcnc_pkg::RATE_DEN) ? qe_q + 1'b1 : qe_q;
    end
  end

  // result register
  logic                         ovalid_q;
  logic [fcnc_pkg::IDX_W-1:0]   oidx_q;
  logic                         ohit_q;
  logic [fcnc_pkg::DIST_W-1:0]  obest_q;
  logic [fcnc_pkg::COLOR_W-1:0] omr_q, omg_q, omb_q;
  logic [fcnc_pkg::RATE_W-1:0]  orate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      oidx_q  <= bidx_q;
      ohit_q  <= hit_q;
      obest_q <= best_q;
      omr_q   <= mr_q;
      omg_q   <= mg_q;
      omb_q   <= mb_q;
      orate_q <= hit_q ? rate_q : '0;
    end
  end

  assign sts_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o    = ovalid_q;
  assign out_matched_o  = ohit_q;
  assign out_data_o     = {3'b000, orate_q, omb_q, omg_q, omr_q, obest_q, oidx_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("pixel count past frame limit");

  a_nomatch_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !ohit_q |->
      obest_q == fcnc_pkg::NO_MATCH_DIST && orate_q == '0 && oidx_q == '0)
    else $error("unmatched result carries class data");

  a_match_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && ohit_q |-> obest_q < fcnc_pkg::NO_MATCH_DIST && oidx_q < CLS_MAX)
    else $error("matched result with out-of-range distance or index");

endmodule

>>> bench/frame_color_nearest_class_test.sv
module frame_color_nearest_class_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_CLASSES       = 6;
  localparam int unsigned MAX_FRAME_PIXELS  = 65536;
  localparam int unsigned IDLE_PCT          = 24;
  localparam int unsigned SETTLE_CYCLES     = 40;
  localparam int unsigned STALL_LIMIT       = 4000;
  localparam int unsigned RANDOM_PHASES     = 8;
  localparam int unsigned PHASE_PIXELS      = 120;
  localparam int unsigned CALM_PHASE        = 3;
  localparam int unsigned LONG_FRAME_PIXELS = 100;

  // index 7 is not mapped to any register
  localparam logic [fcnc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    bit [fcnc_pkg::IDX_W-1:0]   class_index;
    bit                         matched;
    bit [fcnc_pkg::DIST_W-1:0]  best_distance;
    bit [fcnc_pkg::COLOR_W-1:0] mean_red;
    bit [fcnc_pkg::COLOR_W-1:0] mean_green;
    bit [fcnc_pkg::COLOR_W-1:0] mean_blue;
    bit [fcnc_pkg::RATE_W-1:0]  wheel_rate;
  } class_result_t;

  // tracks frame sums and class table, predicts the classification per frame
  class frame_class_scoreboard;
    bit [fcnc_pkg::IDX_W-1:0]  class_count;
    bit [fcnc_pkg::WORD_W-1:0] class_word [MAX_CLASSES];
    bit [23:0]                 red_sum;
    bit [23:0]                 green_sum;
    bit [23:0]                 blue_sum;
    bit [16:0]                 pixel_count;
    class_result_t             expected_q [$];
    int unsigned               failures;

    function new();
      class_count = '0;
      foreach (class_word[i]) class_word[i] = '0;
      red_sum     = '0;
      green_sum   = '0;
      blue_sum    = '0;
      pixel_count = '0;
      failures    = 0;
    endfunction

    function void write_register(bit [fcnc_pkg::CFG_IDX_W-1:0] idx,
                                 bit [fcnc_pkg::WORD_W-1:0] value);
      if (idx == fcnc_pkg::REG_CLASS_COUNT) begin
        class_count = value[fcnc_pkg::IDX_W-1:0];
      end else if (idx >= fcnc_pkg::REG_CLASS_WORD0 &&
                   idx < fcnc_pkg::REG_CLASS_WORD0 + MAX_CLASSES) begin
        class_word[idx - fcnc_pkg::REG_CLASS_WORD0] = value;
      end
    endfunction

    function int unsigned color_gap(bit [fcnc_pkg::COLOR_W-1:0] a,
                                    bit [fcnc_pkg::COLOR_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void note_pixel(bit [fcnc_pkg::COLOR_W-1:0] red,
                             bit [fcnc_pkg::COLOR_W-1:0] green,
                             bit [fcnc_pkg::COLOR_W-1:0] blue, bit last);
      int unsigned   n;
      int unsigned   lim;
      int unsigned   best;
      int unsigned   gap_sum;
      bit [fcnc_pkg::WORD_W-1:0] w;
      class_result_t res;
      // pixels past the frame limit are dropped, tlast still closes the frame
      if (pixel_count < MAX_FRAME_PIXELS) begin
        red_sum     += red;
        green_sum   += green;
        blue_sum    += blue;
        pixel_count += 1;
      end
      if (!last) return;
      n = (pixel_count == 0) ? 1 : pixel_count;
      res.mean_red   = fcnc_pkg::COLOR_W'(red_sum / n);
      res.mean_green = fcnc_pkg::COLOR_W'(green_sum / n);
      res.mean_blue  = fcnc_pkg::COLOR_W'(blue_sum / n);
      lim = (class_count > MAX_CLASSES) ? MAX_CLASSES : class_count;
      best = fcnc_pkg::NO_MATCH_DIST;
      res.class_index = '0;
      res.matched     = 1'b0;
      res.wheel_rate  = '0;
      for (int i = 0; i < lim; i++) begin
        w = class_word[i];
        gap_sum = color_gap(res.mean_red, w[23:16]) + color_gap(res.mean_green, w[15:8]) +
                  color_gap(res.mean_blue, w[7:0]);
        // strict compare: lower index keeps a tie
        if (gap_sum < best) begin
          best            = gap_sum;
          res.class_index = fcnc_pkg::IDX_W'(i);
          res.matched     = 1'b1;
          res.wheel_rate  = fcnc_pkg::RATE_W'((int'(w[39:24]) * 1000 + 571) / 1143);
        end
      end
      res.best_distance = fcnc_pkg::DIST_W'(best);
      expected_q.push_back(res);
      red_sum     = '0;
      green_sum   = '0;
      blue_sum    = '0;
      pixel_count = '0;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [fcnc_pkg::OUT_TDATA_W-1:0] data, logic user);
      class_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                 $time, data, user);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("class_index", want.class_index, data[2:0]);
      compare_field("matched", want.matched, user);
      compare_field("best_distance", want.best_distance, data[12:3]);
      compare_field("mean_red", want.mean_red, data[20:13]);
      compare_field("mean_green", want.mean_green, data[28:21]);
      compare_field("mean_blue", want.mean_blue, data[36:29]);
      compare_field("wheel_rate", want.wheel_rate, data[52:37]);
    endfunction
  endclass

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic [fcnc_pkg::CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [fcnc_pkg::WORD_W-1:0]      cfg_data_i    = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [fcnc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // red, green, blue
  logic                             s_axis_tlast  = 1'b0; // last_pixel
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // class_index, best_distance, mean_red, mean_green, mean_blue, wheel_rate, pad
  logic [fcnc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;  // matched

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  frame_class_scoreboard tracker = new();

  frame_color_nearest_class dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= rx_idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit [fcnc_pkg::WORD_W-1:0] class_entry(
      bit [fcnc_pkg::SPEED_W-1:0] speed, bit [7:0] red, bit [7:0] green, bit [7:0] blue);
    return {speed, red, green, blue};
  endfunction

  function automatic logic [fcnc_pkg::CFG_IDX_W-1:0] word_reg(int unsigned i);
    return fcnc_pkg::REG_CLASS_WORD0 + fcnc_pkg::CFG_IDX_W'(i);
  endfunction

  function automatic bit [7:0] nudge(bit [7:0] base);
    int value;
    value = int'(base) + int'($urandom_range(0, 16)) - 8;
    if (value < 0) value = 0;
    if (value > 255) value = 255;
    return 8'(value);
  endfunction

  // all tasks below start and end at a falling edge
  task automatic write_reg(input logic [fcnc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fcnc_pkg::WORD_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    tracker.write_register(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input bit [7:0] red, input bit [7:0] green, input bit [7:0] blue,
                            input bit last);
    if (tx_idle_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_pixel(red, green, blue, last);
    @(negedge clk_i);
  endtask

  task automatic wait_drained(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned pixels, input bit idle_on);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    bit [7:0]    red;
    bit [7:0]    green;
    bit [7:0]    blue;
    bit [fcnc_pkg::WORD_W-1:0] w;
    wait_drained(SETTLE_CYCLES);
    write_reg(fcnc_pkg::REG_CLASS_COUNT, fcnc_pkg::WORD_W'($urandom_range(0, 7)));
    for (int i = 0; i < MAX_CLASSES; i++) begin
      write_reg(word_reg(i), {8'($urandom), 32'($urandom)});
    end
    tx_idle_on = idle_on;
    rx_idle_on = idle_on;
    sent = 0;
    while (sent < pixels) begin
      len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      for (int j = 0; j < len; j++) begin
        // half the pixels sit near a class color so close calls show up
        if ($urandom_range(0, 1) == 1) begin
          pick  = $urandom_range(0, MAX_CLASSES - 1);
          w     = tracker.class_word[pick];
          red   = nudge(w[23:16]);
          green = nudge(w[15:8]);
          blue  = nudge(w[7:0]);
        end else begin
          red   = 8'($urandom);
          green = 8'($urandom);
          blue  = 8'($urandom);
        end
        send_pixel(red, green, blue, j == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 9) == 0) wait_drained(0);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no classes configured after reset
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);

    wait_drained(SETTLE_CYCLES);
    write_reg(fcnc_pkg::REG_CLASS_COUNT, fcnc_pkg::WORD_W'(6));
    write_reg(word_reg(0), class_entry(16'hFFFF, 8'h00, 8'h00, 8'h00));
    write_reg(word_reg(1), class_entry(16'h0000, 8'hFF, 8'hFF, 8'hFF));
    write_reg(word_reg(2), class_entry(16'h0100, 8'h80, 8'h80, 8'h80));
    // same color as class 2: tie goes to the lower index
    write_reg(word_reg(3), class_entry(16'h1234, 8'h80, 8'h80, 8'h80));
    write_reg(word_reg(4), class_entry(16'hAAAA, 8'h55, 8'hAA, 8'h55));
    write_reg(word_reg(5), class_entry(16'h5555, 8'hAA, 8'h55, 8'hAA));
    write_reg(REG_UNMAPPED, {fcnc_pkg::WORD_W{1'b1}});
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'h80, 8'h80, 8'h80, 1'b1);
    send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
    send_pixel(8'hAA, 8'h55, 8'hAA, 1'b1);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd1, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd254, 1'b1);

    // count above the class table size
    wait_drained(SETTLE_CYCLES);
    write_reg(fcnc_pkg::REG_CLASS_COUNT, fcnc_pkg::WORD_W'(7));
    send_pixel(8'hA0, 8'h50, 8'hB0, 1'b1);

    // distance of exactly 765 is no match
    wait_drained(SETTLE_CYCLES);
    write_reg(fcnc_pkg::REG_CLASS_COUNT, fcnc_pkg::WORD_W'(1));
    write_reg(word_reg(0), {fcnc_pkg::WORD_W{1'b1}});
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd250, 8'd251, 8'd252, 1'b1);

    // long frame, means over many pixels
    wait_drained(SETTLE_CYCLES);
    write_reg(fcnc_pkg::REG_CLASS_COUNT, fcnc_pkg::WORD_W'(3));
    write_reg(word_reg(1), class_entry(16'h0A00, 8'h7F, 8'h7F, 8'h7F));
    write_reg(word_reg(2), class_entry(16'h3200, 8'h20, 8'hC0, 8'h40));
    for (int i = 0; i < LONG_FRAME_PIXELS; i++) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == LONG_FRAME_PIXELS - 1);
    end
    send_pixel(8'd9, 8'd8, 8'd7, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      run_random_phase(PHASE_PIXELS, p != CALM_PHASE);
    end

    wait_drained(SETTLE_CYCLES);
    if (tracker.failures == 0 && tracker.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> frame_color_nearest_class.f
hdl/fcnc_pkg.sv
hdl/fcnc_ctrl.sv
hdl/fcnc_dp.sv
hdl/frame_color_nearest_class.sv
bench/frame_color_nearest_class_test.sv
